FILE: rtl/core/ccpr_pkg.sv
// Shared constants, codes and word types for the clean-first clock page replacer.
package ccpr_pkg;

  localparam int NUM_FRAMES     = 32;
  localparam int NUM_PROCS      = 5;
  localparam int PAGES_PER_PROC = 32;
  localparam int TOTAL_PAGES    = NUM_PROCS * PAGES_PER_PROC;

  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int USED_W  = $clog2(NUM_FRAMES + 1);
  localparam int PROC_W  = 3;
  localparam int PAGE_W  = 5;
  localparam int SLOT_W  = $clog2(TOTAL_PAGES);
  localparam int COUNT_W = 16;
  localparam int ADDR_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0]  REG_MODE  = 3'd0;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_HIT     = 2'd1,
    ST_FILL    = 2'd2,
    ST_REPLACE = 2'd3
  } status_t;

  typedef struct packed {
    logic [PROC_W-1:0] process;
    logic [PAGE_W-1:0] page;
    logic [1:0]        func;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         frame;
    logic [PROC_W-1:0]  victim_process;
    logic [PAGE_W-1:0]  victim_page;
    logic               victim_dirty;
    logic [COUNT_W-1:0] fault_count;
    logic [COUNT_W-1:0] dirty_evict_count;
  } rsp_t;

endpackage

FILE: rtl/core/ccpr_ram.sv
// Generic simple dual-port RAM with registered read.
module ccpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/clean_first_clock_page_replacer_core.sv
// Top level of the clean-first clock page replacer.
//
//   channel  direction  handshake          word
//   req      in         req_valid/stall    process, page, func
//   rsp      out        rsp_valid/stall    status, frame, victim, counts
//   apb      in         psel/penable       replacement_mode at 0
//
// A hit, a no-access word or an ignored word steps through look, decode and
// done; a fill into a free frame adds an install step. A replacement adds the
// victim scan, one frame per cycle through a single compare unit, once round
// the ring globally; local mode scans clean, any-owned, then global fallback.
// Reset clears valid/dirty bits, hands and counts at once; no clearing pass.
// A stalled response holds the sequencer at its last step; the next request
// is taken meanwhile only once the current word sits in the output register.
module clean_first_clock_page_replacer_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  ccpr_pkg::req_t         req,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output ccpr_pkg::rsp_t         rsp,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ccpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import ccpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DEC, S_LOCAL0, S_LOCAL1, S_GLOBAL, S_INSTALL, S_DONE
  } state_t;

  state_t state;
  logic   mode;

  logic [PROC_W-1:0]  proc;
  logic [PAGE_W-1:0]  page;
  kind_t              kind;
  logic [SLOT_W-1:0]  slot;
  status_t            status;
  logic [FRAME_W-1:0] fsel;
  logic [FRAME_W-1:0] scan_i;
  logic               inrange;
  logic [PROC_W-1:0]  vproc;
  logic [PAGE_W-1:0]  vpage;
  logic               vdirty;

  logic [TOTAL_PAGES-1:0] page_valid;
  logic [NUM_FRAMES-1:0]  frame_dirty;
  logic [PROC_W-1:0]      frame_owner [NUM_FRAMES];
  logic [PAGE_W-1:0]      frame_page  [NUM_FRAMES];
  logic [USED_W-1:0]      frames_used;
  logic [FRAME_W-1:0]     global_hand;
  logic [FRAME_W-1:0]     local_hands [NUM_PROCS];
  logic [COUNT_W-1:0]     fault_counts [NUM_PROCS];
  logic [COUNT_W-1:0]     dirty_evict_counts [NUM_PROCS];

  logic [FRAME_W-1:0] ram_rdata;
  logic               ram_we;
  logic [FRAME_W-1:0] gidx, lidx;
  logic [SLOT_W-1:0]  vslot;
  logic               rsp_free;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign pready    = 1'b1;
  assign prdata    = {31'd0, mode};

  assign gidx  = global_hand + scan_i;
  assign lidx  = local_hands[proc] + scan_i;
  assign vslot = SLOT_W'(frame_owner[fsel] * PAGES_PER_PROC) + SLOT_W'(frame_page[fsel]);
  assign ram_we = (state == S_INSTALL);

  ccpr_ram #(.WIDTH(FRAME_W), .DEPTH(TOTAL_PAGES)) u_page_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (fsel),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= 1'b0;
      rsp_valid   <= 1'b0;
      page_valid  <= '0;
      frame_dirty <= '0;
      frames_used <= '0;
      global_hand <= '0;
      for (int p = 0; p < NUM_PROCS; p++) begin
        local_hands[p]        <= '0;
        fault_counts[p]       <= '0;
        dirty_evict_counts[p] <= '0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_MODE) begin
        mode <= pwdata[0];
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            proc    <= req.process;
            page    <= req.page;
            kind    <= kind_t'(req.func);
            inrange <= (32'(req.process) < NUM_PROCS) && (32'(req.page) < PAGES_PER_PROC);
            slot    <= SLOT_W'(req.process * PAGES_PER_PROC) + SLOT_W'(req.page);
            state   <= S_LOOK;
          end
        end
        S_LOOK: state <= S_DEC;
        S_DEC: begin
          scan_i <= '0;
          if (!inrange || !(kind == KIND_READ || kind == KIND_WRITE)) begin
            status <= ST_NONE;
            state  <= S_DONE;
          end else if (page_valid[slot]) begin
            status <= ST_HIT;
            fsel   <= ram_rdata;
            if (kind == KIND_WRITE) begin
              frame_dirty[ram_rdata] <= 1'b1;
            end
            state <= S_DONE;
          end else begin
            if (fault_counts[proc] != COUNT_MAX) begin
              fault_counts[proc] <= fault_counts[proc] + 1'b1;
            end
            if (32'(frames_used) < NUM_FRAMES) begin
              status      <= ST_FILL;
              fsel        <= FRAME_W'(frames_used);
              frames_used <= frames_used + 1'b1;
              state       <= S_INSTALL;
            end else begin
              status <= ST_REPLACE;
              state  <= mode ? S_LOCAL0 : S_GLOBAL;
            end
          end
        end
        S_LOCAL0, S_LOCAL1: begin
          if (frame_owner[lidx] == proc && (state == S_LOCAL1 || !frame_dirty[lidx])) begin
            fsel              <= lidx;
            local_hands[proc] <= lidx + 1'b1;
            state             <= S_INSTALL;
          end else if (scan_i == FRAME_W'(NUM_FRAMES - 1)) begin
            scan_i <= '0;
            state  <= (state == S_LOCAL0) ? S_LOCAL1 : S_GLOBAL;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        S_GLOBAL: begin
          if (!frame_dirty[gidx]) begin
            fsel        <= gidx;
            global_hand <= gidx + 1'b1;
            state       <= S_INSTALL;
          end else if (scan_i == FRAME_W'(NUM_FRAMES - 1)) begin
            // every frame dirty: take the one at the hand
            fsel        <= global_hand;
            global_hand <= global_hand + 1'b1;
            state       <= S_INSTALL;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        S_INSTALL: begin
          // hold the victim here; the output word may still be stalled
          vproc  <= frame_owner[fsel];
          vpage  <= frame_page[fsel];
          vdirty <= frame_dirty[fsel];
          if (status == ST_REPLACE) begin
            page_valid[vslot]  <= 1'b0;
            if (frame_dirty[fsel] && dirty_evict_counts[proc] != COUNT_MAX) begin
              dirty_evict_counts[proc] <= dirty_evict_counts[proc] + 1'b1;
            end
          end
          page_valid[slot]  <= 1'b1;
          frame_owner[fsel] <= proc;
          frame_page[fsel]  <= page;
          frame_dirty[fsel] <= (kind == KIND_WRITE);
          state             <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid  <= 1'b1;
            rsp.status <= status;
            rsp.frame  <= (status == ST_NONE) ? 5'd0 : 5'(fsel);
            if (status == ST_REPLACE) begin
              rsp.victim_process <= vproc;
              rsp.victim_page    <= vpage;
              rsp.victim_dirty   <= vdirty;
            end else begin
              rsp.victim_process <= '0;
              rsp.victim_page    <= '0;
              rsp.victim_dirty   <= 1'b0;
            end
            rsp.fault_count       <= inrange ? fault_counts[proc] : '0;
            rsp.dirty_evict_count <= inrange ? dirty_evict_counts[proc] : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    32'(frames_used) <= NUM_FRAMES)
    else $error("frame fill count past frame total");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken without entering the sequencer");

  a_none_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NONE) |-> (rsp.frame == 5'd0))
    else $error("no-access word carries a frame");

  a_scan_needs_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_GLOBAL || state == S_LOCAL0 || state == S_LOCAL1)
      |-> (32'(frames_used) == NUM_FRAMES))
    else $error("victim scan with free frames left");

endmodule

FILE: test/ccpr_checker.sv
// Checker for the clean-first clock page replacer: predicts each response and compares.
module ccpr_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  ccpr_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  ccpr_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [ccpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]    pwdata,
  output int             errors,
  output int             pending
);
  import ccpr_pkg::*;

  logic            mode;
  logic            pvalid [TOTAL_PAGES];
  logic [4:0]      pframe [TOTAL_PAGES];
  logic            pdirty [TOTAL_PAGES];
  logic [2:0]      fowner [NUM_FRAMES];
  logic [4:0]      fpage  [NUM_FRAMES];
  int              used;
  logic [4:0]      ghand;
  logic [4:0]      lhand  [NUM_PROCS];
  logic [15:0]     faults [NUM_PROCS];
  logic [15:0]     devicts[NUM_PROCS];
  rsp_t            expected_rsp[$];

  assign pending = expected_rsp.size();

  function automatic logic frame_dirty(int f);
    if (fowner[f] >= NUM_PROCS) return 1'b0;
    return pdirty[fowner[f]*PAGES_PER_PROC + fpage[f]];
  endfunction

  function automatic int pick_global_victim();
    int idx;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      idx = (ghand + i) % NUM_FRAMES;
      if (!frame_dirty(idx)) begin
        ghand = 5'(idx + 1);
        return idx;
      end
    end
    idx = ghand;
    ghand = 5'(idx + 1);
    return idx;
  endfunction

  function automatic int pick_victim(int p);
    int idx;
    if (mode) begin
      for (int pass = 0; pass < 2; pass++)
        for (int i = 0; i < NUM_FRAMES; i++) begin
          idx = (lhand[p] + i) % NUM_FRAMES;
          if (fowner[idx] == p && !(pass == 0 && frame_dirty(idx))) begin
            lhand[p] = 5'(idx + 1);
            return idx;
          end
        end
    end
    return pick_global_victim();
  endfunction

  function automatic rsp_t predict_access(req_t r);
    rsp_t o;
    int   p, s, f, vs;
    o = '0;
    p = r.process;
    if (p >= NUM_PROCS) return o;
    s = p*PAGES_PER_PROC + r.page;
    if (r.func == KIND_READ || r.func == KIND_WRITE) begin
      if (pvalid[s]) begin
        o.status = ST_HIT;
        f = pframe[s];
        if (r.func == KIND_WRITE) pdirty[s] = 1'b1;
      end else begin
        if (faults[p] != COUNT_MAX) faults[p]++;
        if (used < NUM_FRAMES) begin
          o.status = ST_FILL;
          f = used;
          used++;
        end else begin
          o.status = ST_REPLACE;
          f = pick_victim(p);
          o.victim_process = fowner[f];
          o.victim_page = fpage[f];
          if (fowner[f] < NUM_PROCS) begin
            vs = fowner[f]*PAGES_PER_PROC + fpage[f];
            o.victim_dirty = pdirty[vs];
            pvalid[vs] = 1'b0;
          end
          if (o.victim_dirty && devicts[p] != COUNT_MAX) devicts[p]++;
        end
        pvalid[s] = 1'b1;
        pframe[s] = 5'(f);
        pdirty[s] = (r.func == KIND_WRITE);
        fowner[f] = 3'(p);
        fpage[f] = r.page;
      end
      o.frame = 5'(f);
    end
    o.fault_count = faults[p];
    o.dirty_evict_count = devicts[p];
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      mode <= 1'b0;
      for (int i = 0; i < TOTAL_PAGES; i++) begin
        pvalid[i] = 1'b0;
        pdirty[i] = 1'b0;
        pframe[i] = '0;
      end
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fowner[i] = '0;
        fpage[i] = '0;
      end
      for (int i = 0; i < NUM_PROCS; i++) begin
        lhand[i] = '0;
        faults[i] = '0;
        devicts[i] = '0;
      end
      used = 0;
      ghand = '0;
      errors = 0;
      expected_rsp.delete();
    end else begin
      if (psel && penable && pwrite && paddr == REG_MODE) mode <= pwdata[0];
      if (req_valid && !req_stall) expected_rsp.push_back(predict_access(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response word %h", rsp);
        end else begin
          want = expected_rsp.pop_front();
          if (want != rsp) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected st=%0d fr=%0d vp=%0d vpg=%0d vd=%0d",
                        " fc=%0d de=%0d, got st=%0d fr=%0d vp=%0d vpg=%0d vd=%0d",
                        " fc=%0d de=%0d"},
                want.status, want.frame, want.victim_process, want.victim_page,
                want.victim_dirty, want.fault_count, want.dirty_evict_count,
                rsp.status, rsp.frame, rsp.victim_process, rsp.victim_page,
                rsp.victim_dirty, rsp.fault_count, rsp.dirty_evict_count);
          end
        end
      end
    end
  end
endmodule

FILE: test/tb_clean_first_clock_page_replacer_core.sv
// Testbench top: drives accesses and mode writes, checks via ccpr_checker.
module tb_clean_first_clock_page_replacer_core;
  import ccpr_pkg::*;

  logic clk = 0, rst = 1;
  logic req_valid = 0, rsp_stall = 0;
  logic req_stall, rsp_valid, pready;
  req_t req = '0;
  rsp_t rsp;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int errors, pending, cycles = 0;
  int rx_gap = 0, tx_gap_max = 16, hold_cycles = 0;
  bit quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  clean_first_clock_page_replacer_core dut (.*);
  ccpr_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("FAIL clean_first_clock_page_replacer_core");
      $finish;
    end
  end

  // receiver stall: long forced hold, random bursts, none at the tail
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      rsp_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet) rsp_stall <= 0;
    else if (rx_gap > 0) begin
      rsp_stall <= 1;
      rx_gap <= rx_gap - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      rsp_stall <= 1;
      rx_gap <= $urandom_range(0, 15);
    end else rsp_stall <= 0;
  end

  // valid stays high across back-to-back words; drop it only for a gap or a drain
  task automatic send_access(logic [2:0] p, logic [4:0] pg, logic [1:0] k);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, tx_gap_max);
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1;
    req <= '{process: p, page: pg, func: k};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    psel <= 1; pwrite <= 1; paddr <= REG_MODE; pwdata <= {31'($urandom), m};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_accesses(int n, int procs_hi);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_access(3'($urandom), 5'($urandom), 2'($urandom));
      else send_access(3'($urandom_range(0, procs_hi)), 5'($urandom_range(0, 15)),
                       ($urandom_range(0, 2) == 0) ? KIND_WRITE : KIND_READ);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: no access, reserved kind, out of range, fills, hits
    send_access(0, 0, KIND_NONE);
    send_access(0, 0, KIND_RSVD);
    send_access(5, 3, KIND_READ);
    send_access(7, 31, KIND_WRITE);
    send_access(0, 0, KIND_READ);
    send_access(0, 0, KIND_WRITE);
    send_access(4, 31, KIND_WRITE);
    send_access(4, 31, KIND_READ);
    send_access(1, 31, KIND_NONE);
    for (int i = 0; i < 16; i++)
      send_access(3'(i % 5), 5'(10 + i), i[0] ? KIND_WRITE : KIND_READ);
    drain();
    // long receiver hold while the sender keeps offering words
    hold_cycles = 400;
    random_accesses(40, 4);
    // sender pause until everything has come back
    drain();
    random_accesses(150, 4);
    write_mode(1);
    random_accesses(150, 4);
    random_accesses(60, 1);
    write_mode(0);
    random_accesses(120, 4);
    write_mode(1);
    random_accesses(60, 4);
    quiet = 1;
    random_accesses(50, 4);
    drain();
    if (errors == 0 && pending == 0) $display("PASS clean_first_clock_page_replacer_core");
    else $display("FAIL clean_first_clock_page_replacer_core");
    $finish;
  end
endmodule
